@@ hw/rtl/sha_pkg.sv @@
// Shared types and constants for the SHA-256 engine.
// No dependencies; used by every module of the block.
package sha_pkg;

    localparam int WQ_DEPTH = 4;
    localparam int WQ_PTR_W = $clog2(WQ_DEPTH);
    localparam int WQ_CNT_W = $clog2(WQ_DEPTH + 1);

    // one 32-bit message-schedule word on its way to the core
    typedef struct packed {
        logic [31:0] word;
        logic        last;   // closes the final block of a message
    } wq_beat_t;

    function automatic logic [31:0] hash_iv(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] v;
        case (idx)
            6'd0:  v = 32'h428a2f98; 6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf; 6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b; 6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4; 6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98; 6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7; 6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f; 6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8; 6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85; 6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e; 6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819; 6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c; 6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee; 6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;
            default: v = 32'hc67178f2;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/sha256_hash_engine.sv @@
// SHA-256 engine top level: front end, word queue and compression core.
// Depends on sha_pkg, sha_front, sha_wq, sha_core.
//
// Input channel: one beat per push when full is low. A beat carries
// data_byte (used when byte_present is set) and message_end. A beat with
// message_end closes the message: padding and the bit length are appended.
// Result channel: eight beats per message, digest words H0..H7, each with
// word_index and final_word on the last one; a beat is taken by pop while
// empty is low.
// Throughput: one round per cycle while the core is not waiting on the word
// queue, 64 rounds plus an add step per block. The first 16 rounds wait on
// words packed by the front end, which then stalls on the full word queue.
// Padding pushes 3 to 18 words with full high. The digest follows once the
// one or two final blocks and rounds still pending have run.
// Reset clears lengths and fill, loads the initial hash values, empties
// both queues. If pop is held low, the finished digest waits in its buffer;
// the core still runs the next message and stalls only when a second digest
// is ready, and then the word queue fills and full rises.
module sha256_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        message_end,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        final_word
);

    logic              wq_push, wq_full, wq_pop, wq_empty;
    sha_pkg::wq_beat_t wq_in, wq_out;

    sha_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .message_end  (message_end),
        .wq_push      (wq_push),
        .wq_beat      (wq_in),
        .wq_full      (wq_full)
    );

    sha_wq u_wq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wq_push),
        .wr_beat (wq_in),
        .full    (wq_full),
        .rd_en   (wq_pop),
        .rd_beat (wq_out),
        .empty   (wq_empty)
    );

    sha_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .wq_empty    (wq_empty),
        .wq_beat     (wq_out),
        .wq_pop      (wq_pop),
        .empty       (empty),
        .pop         (pop),
        .digest_word (digest_word),
        .word_index  (word_index),
        .final_word  (final_word)
    );

endmodule

@@ hw/rtl/sha_front.sv @@
// Front end: packs message bytes into words, tracks length, appends padding.
// Depends on sha_pkg.
module sha_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         data_byte,
    input  logic               byte_present,
    input  logic               message_end,
    output logic               wq_push,
    output sha_pkg::wq_beat_t  wq_beat,
    input  logic               wq_full
);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_PAD1 = 5'b00010,
        F_ZERO = 5'b00100,
        F_LENH = 5'b01000,
        F_LENL = 5'b10000
    } fstate_t;

    fstate_t     state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] total_reg, total_next;
    logic [23:0] acc_reg, acc_next;
    logic        accept;
    logic [3:0]  slot_inc;

    assign full     = (state_reg != F_IDLE) || wq_full;
    assign accept   = push && !full;
    assign slot_inc = fill_reg[5:2] + 4'd1;

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        total_next   = total_reg;
        acc_next     = acc_reg;
        wq_push      = 1'b0;
        wq_beat.word = 32'h0;
        wq_beat.last = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (byte_present)
                    begin
                        fill_next  = fill_reg + 6'd1;
                        total_next = total_reg + 61'd1;
                        case (fill_reg[1:0])
                            2'd0: acc_next[23:16] = data_byte;
                            2'd1: acc_next[15:8]  = data_byte;
                            2'd2: acc_next[7:0]   = data_byte;
                            default:
                            begin
                                wq_push      = 1'b1;
                                wq_beat.word = {acc_reg, data_byte};
                            end
                        endcase
                    end
                    if (message_end)
                        state_next = F_PAD1;
                end
            end
            F_PAD1:
            begin
                // partial word, then the 0x80 marker, then zeros
                case (fill_reg[1:0])
                    2'd0: wq_beat.word = 32'h80000000;
                    2'd1: wq_beat.word = {acc_reg[23:16], 8'h80, 16'h0};
                    2'd2: wq_beat.word = {acc_reg[23:8], 8'h80, 8'h0};
                    default: wq_beat.word = {acc_reg, 8'h80};
                endcase
                if (!wq_full)
                begin
                    wq_push    = 1'b1;
                    fill_next  = {slot_inc, 2'b00};
                    state_next = (slot_inc == 4'd14) ? F_LENH : F_ZERO;
                end
            end
            F_ZERO:
            begin
                if (!wq_full)
                begin
                    wq_push    = 1'b1;
                    fill_next  = {slot_inc, 2'b00};
                    if (slot_inc == 4'd14)
                        state_next = F_LENH;
                end
            end
            F_LENH:
            begin
                wq_beat.word = total_reg[60:29];
                if (!wq_full)
                begin
                    wq_push    = 1'b1;
                    state_next = F_LENL;
                end
            end
            F_LENL:
            begin
                wq_beat.word = {total_reg[28:0], 3'b000};
                wq_beat.last = 1'b1;
                if (!wq_full)
                begin
                    wq_push    = 1'b1;
                    fill_next  = 6'd0;
                    total_next = 61'd0;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            fill_reg  <= 6'd0;
            total_reg <= 61'd0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

endmodule

@@ hw/rtl/sha_wq.sv @@
// Short word queue between the front end and the compression core.
// Depends on sha_pkg.
module sha_wq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  sha_pkg::wq_beat_t  wr_beat,
    output logic               full,
    input  logic               rd_en,
    output sha_pkg::wq_beat_t  rd_beat,
    output logic               empty
);

    sha_pkg::wq_beat_t                 mem_reg [sha_pkg::WQ_DEPTH];
    logic [sha_pkg::WQ_PTR_W-1:0]      wp_reg, rp_reg;
    logic [sha_pkg::WQ_CNT_W-1:0]      cnt_reg;
    logic                              do_wr, do_rd;

    assign full    = (cnt_reg == sha_pkg::WQ_CNT_W'(sha_pkg::WQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_beat = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= wp_reg + sha_pkg::WQ_PTR_W'(1);
            if (do_rd)
                rp_reg <= rp_reg + sha_pkg::WQ_PTR_W'(1);
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + sha_pkg::WQ_CNT_W'(1);
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - sha_pkg::WQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_beat;
    end

endmodule

@@ hw/rtl/sha_core.sv @@
// Back end: message schedule, one compression round per cycle unless waiting on the word queue, digest buffer.
// Depends on sha_pkg.
module sha_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wq_empty,
    input  sha_pkg::wq_beat_t  wq_beat,
    output logic               wq_pop,
    output logic               empty,
    input  logic               pop,
    output logic [31:0]        digest_word,
    output logic [2:0]         word_index,
    output logic               final_word
);

    typedef enum logic [2:0] {
        C_RUN  = 3'b001,
        C_ADD  = 3'b010,
        C_DONE = 3'b100
    } cstate_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int r);
        return (x >> r) | (x << (32 - r));
    endfunction

    cstate_t     state_reg;
    logic [5:0]  t_reg;
    logic        last_reg;
    logic [31:0] h_reg   [8];
    logic [31:0] v_reg   [8];
    logic [31:0] w_reg   [16];
    logic [31:0] dig_reg [8];
    logic        out_valid_reg;
    logic [2:0]  out_idx_reg;

    logic        sched_phase;
    logic        adv;
    logic [31:0] w_cur, sig0, sig1, big0, big1, ch, maj, t1, t2;
    logic [31:0] hsum [8];

    assign sched_phase = (t_reg[5:4] != 2'b00);
    assign wq_pop      = (state_reg == C_RUN) && !sched_phase && !wq_empty;
    assign adv         = (state_reg == C_RUN) && (sched_phase || !wq_empty);

    always_comb
    begin
        sig0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        sig1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_cur = sched_phase ? (w_reg[0] + sig0 + w_reg[9] + sig1) : wq_beat.word;
        big1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        big0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1   = v_reg[7] + big1 + ch + sha_pkg::round_k(t_reg) + w_cur;
        t2   = big0 + maj;
        for (int i = 0; i < 8; i++)
            hsum[i] = h_reg[i] + v_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_RUN;
            t_reg         <= 6'd0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::hash_iv(3'(i));
                v_reg[i] <= sha_pkg::hash_iv(3'(i));
            end
        end
        else
        begin
            unique case (state_reg)
                C_RUN:
                begin
                    if (adv)
                    begin
                        v_reg[0] <= t1 + t2;
                        v_reg[1] <= v_reg[0];
                        v_reg[2] <= v_reg[1];
                        v_reg[3] <= v_reg[2];
                        v_reg[4] <= v_reg[3] + t1;
                        v_reg[5] <= v_reg[4];
                        v_reg[6] <= v_reg[5];
                        v_reg[7] <= v_reg[6];
                        t_reg    <= t_reg + 6'd1;
                        if (wq_pop && t_reg == 6'd15)
                            last_reg <= wq_beat.last;
                        if (t_reg == 6'd63)
                            state_reg <= C_ADD;
                    end
                end
                C_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= hsum[i];
                        v_reg[i] <= hsum[i];
                    end
                    state_reg <= last_reg ? C_DONE : C_RUN;
                end
                C_DONE:
                begin
                    // wait until the previous digest has drained
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_idx_reg   <= 3'd0;
                        for (int i = 0; i < 8; i++)
                        begin
                            h_reg[i] <= sha_pkg::hash_iv(3'(i));
                            v_reg[i] <= sha_pkg::hash_iv(3'(i));
                        end
                        state_reg <= C_RUN;
                    end
                end
                default: state_reg <= C_RUN;
            endcase

            if (out_valid_reg && pop)
            begin
                out_idx_reg <= out_idx_reg + 3'd1;
                if (out_idx_reg == 3'd7)
                    out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_cur;
        end
        if (state_reg == C_DONE && !out_valid_reg)
        begin
            for (int i = 0; i < 8; i++)
                dig_reg[i] <= h_reg[i];
        end
    end

    assign empty       = !out_valid_reg;
    assign digest_word = dig_reg[out_idx_reg];
    assign word_index  = out_idx_reg;
    assign final_word  = (out_idx_reg == 3'd7);

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        wq_pop |-> !wq_empty) else $error("word queue popped while empty");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("core state not one-hot");

    a_add_after_last_round: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && t_reg == 6'd63) |=> (state_reg == C_ADD && t_reg == 6'd0))
        else $error("block did not close after round 63");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_DONE && out_valid_reg && !pop) |=> (state_reg == C_DONE))
        else $error("digest overwritten before drained");

endmodule
